@@ rtl/ccs_pkg.sv @@
`timescale 1ns / 1ps

package ccs_pkg;

    // object store size and the widths that follow from it
    localparam int MAX_OBJECTS = 64;
    localparam int IDX_W       = $clog2(MAX_OBJECTS);
    localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

    // fixed field widths
    localparam int VAL_W      = 20;
    localparam int RAD_W      = 16;
    localparam int DT_W       = 16;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int FACT_W     = 18;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // memory word layouts
    localparam int POS_W = RAD_W + 2 * VAL_W;
    localparam int VEL_W = 2 * VAL_W;

    // request kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_BOUNCE  = 3'd3;

    // register reset values
    localparam logic [COUNT_W-1:0]       COUNT_RST  = 7'd1;
    localparam logic signed [VAL_W-1:0]  ACCEL_X_RST = 20'sd0;
    localparam logic signed [VAL_W-1:0]  ACCEL_Y_RST = -20'sd106168;
    localparam logic signed [FACT_W-1:0] BOUNCE_RST  = -18'sd55705;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 20'h7FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 20'h80000;

    // clamp a wide signed value into the Q3.16 range
    function automatic logic signed [VAL_W-1:0] sat20(input logic signed [63:0] v);
        if (v > 64'sd524287)
            return VAL_MAX;
        else if (v < -64'sd524288)
            return VAL_MIN;
        else
            return v[VAL_W-1:0];
    endfunction

endpackage

@@ rtl/ccs_ram.sv @@
`timescale 1ns / 1ps

module ccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/circle_collision_step.sv @@
`timescale 1ns / 1ps

// Circle collision stepper. Objects live in two single-port-write memories
// (position with radius, and velocity). A load request writes one slot in the
// cycle it is accepted. A tick request runs, for each active object k, a wall
// bounce, a full pass over every pair i<j, and an integration step, then
// reports every active object in slot order with tlast on the final one.
// All products go through one shared registered 25x33 multiplier; each
// velocity exchange uses a one-bit-per-cycle divider of 64 steps. A pair that
// does not touch, or that sits at one point, skips the exchange; a stalled
// result holds back the rest of the report.
// The block takes no request during a tick; the last result may still wait
// on m_tready while the next request is accepted.
module circle_collision_step import ccs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // request: tuser = func
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // index, pos_x, pos_y, vel_x, vel_y, radius, time_step, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    // result: tlast = last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // obj_index, new_pos_x, new_pos_y, new_vel_x, new_vel_y, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // register writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_PRE0   = 6'd1;
    localparam logic [5:0] S_PRE1   = 6'd2;
    localparam logic [5:0] S_PRE2   = 6'd3;
    localparam logic [5:0] S_PRE3   = 6'd4;
    localparam logic [5:0] S_PRE4   = 6'd5;
    localparam logic [5:0] S_PRE5   = 6'd6;
    localparam logic [5:0] S_W_RD   = 6'd7;
    localparam logic [5:0] S_W_EV   = 6'd8;
    localparam logic [5:0] S_W_WR   = 6'd9;
    localparam logic [5:0] S_P_IRD  = 6'd10;
    localparam logic [5:0] S_P_ILD  = 6'd11;
    localparam logic [5:0] S_P_JRD  = 6'd12;
    localparam logic [5:0] S_P_J0   = 6'd13;
    localparam logic [5:0] S_P_J1   = 6'd14;
    localparam logic [5:0] S_P_J2   = 6'd15;
    localparam logic [5:0] S_P_J3   = 6'd16;
    localparam logic [5:0] S_P_J4   = 6'd17;
    localparam logic [5:0] S_P_J5   = 6'd18;
    localparam logic [5:0] S_P_J6   = 6'd19;
    localparam logic [5:0] S_E0     = 6'd20;
    localparam logic [5:0] S_E1     = 6'd21;
    localparam logic [5:0] S_E2     = 6'd22;
    localparam logic [5:0] S_DIV    = 6'd23;
    localparam logic [5:0] S_E3     = 6'd24;
    localparam logic [5:0] S_P_JWR  = 6'd25;
    localparam logic [5:0] S_P_JNX  = 6'd26;
    localparam logic [5:0] S_INT_RD = 6'd27;
    localparam logic [5:0] S_INT_LD = 6'd28;
    localparam logic [5:0] S_INT_M0 = 6'd29;
    localparam logic [5:0] S_INT_M1 = 6'd30;
    localparam logic [5:0] S_INT_M2 = 6'd31;
    localparam logic [5:0] S_O_RD   = 6'd32;
    localparam logic [5:0] S_O_WT   = 6'd33;

    // request fields
    logic                     in_func;
    logic [SLOT_W-1:0]        in_index;
    logic [VAL_W-1:0]         in_pos_x;
    logic [VAL_W-1:0]         in_pos_y;
    logic [VAL_W-1:0]         in_vel_x;
    logic [VAL_W-1:0]         in_vel_y;
    logic [RAD_W-1:0]         in_radius;
    logic [DT_W-1:0]          in_time_step;
    logic                     in_acc;

    assign in_func      = s_tuser;
    assign in_index     = s_tdata[5:0];
    assign in_pos_x     = s_tdata[25:6];
    assign in_pos_y     = s_tdata[45:26];
    assign in_vel_x     = s_tdata[65:46];
    assign in_vel_y     = s_tdata[85:66];
    assign in_radius    = s_tdata[101:86];
    assign in_time_step = s_tdata[117:102];

    // control state
    logic [5:0]               state_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [CNT_W-1:0]         j_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [5:0]               div_cnt_reg;
    logic                     axis_reg;
    logic                     m_tvalid_reg;
    logic                     m_tlast_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;

    // configuration
    logic [COUNT_W-1:0]       count_reg;
    logic signed [VAL_W-1:0]  accel_x_reg;
    logic signed [VAL_W-1:0]  accel_y_reg;
    logic signed [FACT_W-1:0] bounce_reg;

    // tick constants
    logic [DT_W-1:0]          dt_reg;
    logic [2*DT_W-1:0]        dtdt_reg;
    logic signed [35:0]       axdt_reg;
    logic signed [35:0]       aydt_reg;
    logic signed [51:0]       axdtdt_reg;
    logic signed [51:0]       aydtdt_reg;

    // working object registers
    logic signed [VAL_W-1:0]  xi_reg;
    logic signed [VAL_W-1:0]  yi_reg;
    logic [RAD_W-1:0]         ri_reg;
    logic signed [VAL_W-1:0]  vxi_reg;
    logic signed [VAL_W-1:0]  vyi_reg;
    logic signed [VAL_W-1:0]  vxj_reg;
    logic signed [VAL_W-1:0]  vyj_reg;
    logic                     hit_x_reg;
    logic                     hit_y_reg;
    logic signed [20:0]       dx_reg;
    logic signed [20:0]       dy_reg;
    logic [16:0]              lim_reg;
    logic [42:0]              d2_reg;
    logic [42:0]              s_abs_reg;
    logic                     s_neg_reg;
    logic                     e_neg_reg;
    logic [63:0]              dvd_reg;
    logic [43:0]              rem_reg;

    // shared multiplier
    logic signed [24:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [57:0]       prod_reg;
    logic signed [57:0]       acc_reg;

    // memory ports
    logic                     pos_we;
    logic                     vel_we;
    logic [IDX_W-1:0]         waddr;
    logic [POS_W-1:0]         pos_wdata;
    logic [VEL_W-1:0]         vel_wdata;
    logic                     rd_en;
    logic [IDX_W-1:0]         raddr;
    logic [POS_W-1:0]         pos_rdata;
    logic [VEL_W-1:0]         vel_rdata;

    // read data fields
    logic signed [VAL_W-1:0]  rd_x;
    logic signed [VAL_W-1:0]  rd_y;
    logic [RAD_W-1:0]         rd_r;
    logic signed [VAL_W-1:0]  rd_vx;
    logic signed [VAL_W-1:0]  rd_vy;

    assign rd_x  = pos_rdata[VAL_W-1:0];
    assign rd_y  = pos_rdata[2*VAL_W-1:VAL_W];
    assign rd_r  = pos_rdata[POS_W-1:2*VAL_W];
    assign rd_vx = vel_rdata[VAL_W-1:0];
    assign rd_vy = vel_rdata[2*VAL_W-1:VAL_W];

    // derived values
    logic signed [16:0]       rd_r_s;
    logic signed [21:0]       wx_hi;
    logic signed [21:0]       wx_lo;
    logic signed [21:0]       wy_hi;
    logic signed [21:0]       wy_lo;
    logic                     hit_x;
    logic                     hit_y;
    logic signed [VAL_W-1:0]  bounce_v;
    logic signed [20:0]       dvx;
    logic signed [20:0]       dvy;
    logic [20:0]              abs_d;
    logic                     d_neg;
    logic signed [57:0]       prod_sum;
    logic [63:0]              num;
    logic [43:0]              rem_sh;
    logic                     rem_ge;
    logic signed [23:0]       e_val;
    logic signed [VAL_W-1:0]  new_x;
    logic signed [VAL_W-1:0]  new_y;
    logic signed [VAL_W-1:0]  new_vx;
    logic signed [VAL_W-1:0]  new_vy;
    logic [CNT_W:0]           n_ext;
    logic [CNT_W:0]           i_inc;
    logic [CNT_W:0]           j_inc;
    logic [CNT_W:0]           k_inc;

    assign n_ext = (CNT_W+1)'(n_reg);
    assign i_inc = (CNT_W+1)'(i_reg) + 1'b1;
    assign j_inc = (CNT_W+1)'(j_reg) + 1'b1;
    assign k_inc = (CNT_W+1)'(k_reg) + 1'b1;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // wall test on freshly read object
    assign rd_r_s = signed'({1'b0, rd_r});
    assign wx_hi  = 22'(rd_x) + 22'(rd_r_s);
    assign wx_lo  = 22'(rd_x) - 22'(rd_r_s);
    assign wy_hi  = 22'(rd_y) + 22'(rd_r_s);
    assign wy_lo  = 22'(rd_y) - 22'(rd_r_s);
    assign hit_x  = (wx_hi > 22'sd65536) || (wx_lo < -22'sd65536);
    assign hit_y  = (wy_hi > 22'sd65536) || (wy_lo < -22'sd65536);

    assign bounce_v = sat20((64'(prod_reg) + 64'sd32768) >>> 16);

    // pair terms
    assign dvx      = 21'(vxj_reg) - 21'(vxi_reg);
    assign dvy      = 21'(vyj_reg) - 21'(vyi_reg);
    assign d_neg    = axis_reg ? dy_reg[20] : dx_reg[20];
    assign abs_d    = axis_reg ? (dy_reg[20] ? 21'(-dy_reg) : 21'(dy_reg))
                               : (dx_reg[20] ? 21'(-dx_reg) : 21'(dx_reg));
    assign prod_sum = acc_reg + prod_reg;
    assign num      = 64'(acc_reg) + (64'(prod_reg) << 22);

    // divider step
    assign rem_sh = {rem_reg[42:0], dvd_reg[63]};
    assign rem_ge = rem_sh >= {1'b0, d2_reg};
    assign e_val  = e_neg_reg ? -24'(dvd_reg[22:0]) : 24'(dvd_reg[22:0]);

    // integration results
    assign new_x  = sat20(((64'(xi_reg) <<< 33) + (64'(acc_reg) <<< 17) + 64'(axdtdt_reg)
                           + 64'sd4294967296) >>> 33);
    assign new_y  = sat20(((64'(yi_reg) <<< 33) + (64'(prod_reg) <<< 17) + 64'(aydtdt_reg)
                           + 64'sd4294967296) >>> 33);
    assign new_vx = sat20(((64'(vxi_reg) <<< 16) + 64'(axdt_reg) + 64'sd32768) >>> 16);
    assign new_vy = sat20(((64'(vyi_reg) <<< 16) + 64'(aydt_reg) + 64'sd32768) >>> 16);

    // memory and multiplier steering
    always_comb
    begin
        pos_we    = 1'b0;
        vel_we    = 1'b0;
        waddr     = k_reg[IDX_W-1:0];
        pos_wdata = {ri_reg, new_y, new_x};
        vel_wdata = {new_vy, new_vx};
        rd_en     = 1'b0;
        raddr     = k_reg[IDX_W-1:0];
        mul_a     = 25'sd0;
        mul_b     = 33'sd0;
        case (state_reg)
            S_IDLE:
            begin
                waddr     = IDX_W'(in_index);
                pos_wdata = {in_radius, in_pos_y, in_pos_x};
                vel_wdata = {in_vel_y, in_vel_x};
                if (in_acc && in_func == FUNC_LOAD && int'(in_index) < MAX_OBJECTS)
                begin
                    pos_we = 1'b1;
                    vel_we = 1'b1;
                end
            end
            S_PRE0:
            begin
                mul_a = 25'(dt_reg);
                mul_b = 33'(dt_reg);
            end
            S_PRE1:
            begin
                mul_a = 25'(accel_x_reg);
                mul_b = 33'(dt_reg);
            end
            S_PRE2:
            begin
                mul_a = 25'(accel_y_reg);
                mul_b = 33'(dt_reg);
            end
            S_PRE3:
            begin
                mul_a = 25'(accel_x_reg);
                mul_b = 33'(dtdt_reg);
            end
            S_PRE4:
            begin
                mul_a = 25'(accel_y_reg);
                mul_b = 33'(dtdt_reg);
            end
            S_W_RD, S_INT_RD, S_O_RD:
            begin
                rd_en = 1'b1;
            end
            S_W_EV:
            begin
                mul_a = hit_x ? 25'(rd_vx) : 25'(rd_vy);
                mul_b = 33'(bounce_reg);
            end
            S_W_WR:
            begin
                vel_we    = hit_x_reg || hit_y_reg;
                vel_wdata = hit_x_reg ? {vyi_reg, bounce_v} : {bounce_v, vxi_reg};
            end
            S_P_IRD:
            begin
                rd_en = 1'b1;
                raddr = i_reg[IDX_W-1:0];
            end
            S_P_JRD:
            begin
                rd_en = 1'b1;
                raddr = j_reg[IDX_W-1:0];
            end
            S_P_J1:
            begin
                mul_a = 25'(dx_reg);
                mul_b = 33'(dx_reg);
            end
            S_P_J2:
            begin
                mul_a = 25'(dy_reg);
                mul_b = 33'(dy_reg);
            end
            S_P_J3:
            begin
                mul_a = 25'(lim_reg);
                mul_b = 33'(lim_reg);
            end
            S_P_J4:
            begin
                mul_a = 25'(dvx);
                mul_b = 33'(dx_reg);
            end
            S_P_J5:
            begin
                mul_a = 25'(dvy);
                mul_b = 33'(dy_reg);
            end
            S_E0:
            begin
                mul_a = 25'(abs_d);
                mul_b = 33'(s_abs_reg[21:0]);
            end
            S_E1:
            begin
                mul_a = 25'(abs_d);
                mul_b = 33'(s_abs_reg[42:22]);
            end
            S_P_JWR:
            begin
                vel_we    = 1'b1;
                waddr     = j_reg[IDX_W-1:0];
                vel_wdata = {vyj_reg, vxj_reg};
            end
            S_P_JNX:
            begin
                vel_we    = (j_inc >= n_ext);
                waddr     = i_reg[IDX_W-1:0];
                vel_wdata = {vyi_reg, vxi_reg};
            end
            S_INT_M0:
            begin
                mul_a = 25'(vxi_reg);
                mul_b = 33'(dt_reg);
            end
            S_INT_M1:
            begin
                mul_a = 25'(vyi_reg);
                mul_b = 33'(dt_reg);
            end
            S_INT_M2:
            begin
                pos_we = 1'b1;
                vel_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    ccs_ram #(.WIDTH(POS_W), .DEPTH(MAX_OBJECTS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (waddr),
        .wdata (pos_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (pos_rdata)
    );

    ccs_ram #(.WIDTH(VEL_W), .DEPTH(MAX_OBJECTS)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (waddr),
        .wdata (vel_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (vel_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= COUNT_RST;
            accel_x_reg <= ACCEL_X_RST;
            accel_y_reg <= ACCEL_Y_RST;
            bounce_reg  <= BOUNCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OBJECT_COUNT: count_reg   <= cfg_data[COUNT_W-1:0];
                REG_ACCEL_X:      accel_x_reg <= cfg_data[VAL_W-1:0];
                REG_ACCEL_Y:      accel_y_reg <= cfg_data[VAL_W-1:0];
                REG_WALL_BOUNCE:  bounce_reg  <= cfg_data[FACT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // shared multiplier output
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            div_cnt_reg  <= '0;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_func == FUNC_TICK)
                    begin
                        dt_reg    <= in_time_step;
                        n_reg     <= (int'(count_reg) > MAX_OBJECTS) ?
                                     CNT_W'(MAX_OBJECTS) : CNT_W'(count_reg);
                        state_reg <= S_PRE0;
                    end
                end
                S_PRE0:
                begin
                    state_reg <= (n_reg == '0) ? S_IDLE : S_PRE1;
                end
                S_PRE1:
                begin
                    dtdt_reg  <= prod_reg[2*DT_W-1:0];
                    state_reg <= S_PRE2;
                end
                S_PRE2:
                begin
                    axdt_reg  <= prod_reg[35:0];
                    state_reg <= S_PRE3;
                end
                S_PRE3:
                begin
                    aydt_reg  <= prod_reg[35:0];
                    state_reg <= S_PRE4;
                end
                S_PRE4:
                begin
                    axdtdt_reg <= prod_reg[51:0];
                    state_reg  <= S_PRE5;
                end
                S_PRE5:
                begin
                    aydtdt_reg <= prod_reg[51:0];
                    k_reg      <= '0;
                    state_reg  <= S_W_RD;
                end
                // wall bounce of object k
                S_W_RD:
                begin
                    state_reg <= S_W_EV;
                end
                S_W_EV:
                begin
                    vxi_reg   <= rd_vx;
                    vyi_reg   <= rd_vy;
                    hit_x_reg <= hit_x;
                    hit_y_reg <= !hit_x && hit_y;
                    state_reg <= S_W_WR;
                end
                S_W_WR:
                begin
                    i_reg     <= '0;
                    state_reg <= S_P_IRD;
                end
                // pair pass
                S_P_IRD:
                begin
                    state_reg <= (i_inc >= n_ext) ? S_INT_RD : S_P_ILD;
                end
                S_P_ILD:
                begin
                    xi_reg    <= rd_x;
                    yi_reg    <= rd_y;
                    ri_reg    <= rd_r;
                    vxi_reg   <= rd_vx;
                    vyi_reg   <= rd_vy;
                    j_reg     <= i_inc[CNT_W-1:0];
                    state_reg <= S_P_JRD;
                end
                S_P_JRD:
                begin
                    state_reg <= S_P_J0;
                end
                S_P_J0:
                begin
                    vxj_reg   <= rd_vx;
                    vyj_reg   <= rd_vy;
                    dx_reg    <= 21'(rd_x) - 21'(xi_reg);
                    dy_reg    <= 21'(rd_y) - 21'(yi_reg);
                    lim_reg   <= 17'(rd_r) + 17'(ri_reg);
                    state_reg <= S_P_J1;
                end
                S_P_J1:
                begin
                    state_reg <= S_P_J2;
                end
                S_P_J2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_P_J3;
                end
                S_P_J3:
                begin
                    d2_reg    <= prod_sum[42:0];
                    state_reg <= S_P_J4;
                end
                S_P_J4:
                begin
                    // coincident or apart: no exchange
                    if (d2_reg == '0 || d2_reg > 43'(prod_reg[33:0]))
                        state_reg <= S_P_JNX;
                    else
                        state_reg <= S_P_J5;
                end
                S_P_J5:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_P_J6;
                end
                S_P_J6:
                begin
                    s_neg_reg <= prod_sum[57];
                    s_abs_reg <= prod_sum[57] ? 43'(-prod_sum) : prod_sum[42:0];
                    axis_reg  <= 1'b0;
                    state_reg <= S_E0;
                end
                // normal exchange, x then y
                S_E0:
                begin
                    state_reg <= S_E1;
                end
                S_E1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_E2;
                end
                S_E2:
                begin
                    dvd_reg     <= num + 64'(d2_reg >> 1);
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    e_neg_reg   <= d_neg ^ s_neg_reg;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg     <= rem_ge ? (rem_sh - {1'b0, d2_reg}) : rem_sh;
                    dvd_reg     <= {dvd_reg[62:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 6'd63)
                        state_reg <= S_E3;
                end
                S_E3:
                begin
                    if (!axis_reg)
                    begin
                        vxi_reg   <= sat20(64'(vxi_reg) + 64'(e_val));
                        vxj_reg   <= sat20(64'(vxj_reg) - 64'(e_val));
                        axis_reg  <= 1'b1;
                        state_reg <= S_E0;
                    end
                    else
                    begin
                        vyi_reg   <= sat20(64'(vyi_reg) + 64'(e_val));
                        vyj_reg   <= sat20(64'(vyj_reg) - 64'(e_val));
                        state_reg <= S_P_JWR;
                    end
                end
                S_P_JWR:
                begin
                    state_reg <= S_P_JNX;
                end
                S_P_JNX:
                begin
                    if (j_inc >= n_ext)
                    begin
                        i_reg     <= i_inc[CNT_W-1:0];
                        state_reg <= S_P_IRD;
                    end
                    else
                    begin
                        j_reg     <= j_inc[CNT_W-1:0];
                        state_reg <= S_P_JRD;
                    end
                end
                // integration of object k
                S_INT_RD:
                begin
                    state_reg <= S_INT_LD;
                end
                S_INT_LD:
                begin
                    xi_reg    <= rd_x;
                    yi_reg    <= rd_y;
                    ri_reg    <= rd_r;
                    vxi_reg   <= rd_vx;
                    vyi_reg   <= rd_vy;
                    state_reg <= S_INT_M0;
                end
                S_INT_M0:
                begin
                    state_reg <= S_INT_M1;
                end
                S_INT_M1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_INT_M2;
                end
                S_INT_M2:
                begin
                    if (k_inc >= n_ext)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_O_RD;
                    end
                    else
                    begin
                        k_reg     <= k_inc[CNT_W-1:0];
                        state_reg <= S_W_RD;
                    end
                end
                // report
                S_O_RD:
                begin
                    state_reg <= S_O_WT;
                end
                S_O_WT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, rd_vy, rd_vx, rd_y, rd_x,
                                         SLOT_W'(k_reg)};
                        m_tlast_reg  <= (k_inc >= n_ext);
                        if (k_inc >= n_ext)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_inc[CNT_W-1:0];
                            state_reg <= S_O_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/ccs_checker.sv @@
`timescale 1ns / 1ps

module ccs_checker import ccs_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a tick request closes the request side
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_TICK |=> !s_tready)
        else $error("request taken right after a tick");

    // more results of the same tick still to come, either pending or being built
    a_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready || m_tvalid)
        else $error("request side open in the middle of a report");

    // only the final result may wait while the block is idle
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && s_tready |-> m_tlast)
        else $error("non-final result pending while idle");

endmodule

bind circle_collision_step ccs_checker u_ccs_checker (.*);
